// ===== rtl/core/dwfa_pkg.sv =====
// Shared types and constants for the double-well force accumulator.
// Holds fixed-point constants, state encodings and the sequencer's micro-op table.
// No dependencies.
`default_nettype none

package dwfa_pkg;

    // Fixed-point layout
    localparam int RES_FRAC    = 16;
    localparam int COORD_FRAC  = 12;
    localparam int COEF_FRAC   = 8;
    localparam int COORD_SHIFT = RES_FRAC - COORD_FRAC;
    localparam int COEF_SHIFT  = RES_FRAC - COEF_FRAC;
    localparam int COEF_WIDTH  = 16;

    // Reset values of the coefficient registers (Q8.8)
    localparam logic [COEF_WIDTH-1:0] WELL_DEPTH_RESET = 16'h0100;
    localparam logic [COEF_WIDTH-1:0] TILT_RESET       = 16'h0000;

    // Multiplier digit width and queue depth
    localparam int MUL_DIGIT   = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [0:0] {
        CFG_WELL_DEPTH = 1'b0,
        CFG_TILT       = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        M_IDLE  = 3'b001,
        M_RUN   = 3'b010,
        M_ROUND = 3'b100
    } mul_state_t;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_ISSUE = 4'b0010,
        B_WAIT  = 4'b0100,
        B_OUT   = 4'b1000
    } back_state_t;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        R_X    = 4'd0,
        R_A    = 4'd1,
        R_B    = 4'd2,
        R_S    = 4'd3,
        R_D    = 4'd4,
        R_XP1  = 4'd5,
        R_T    = 4'd6,
        R_V    = 4'd7,
        R_F    = 4'd8,
        R_L    = 4'd9,
        R_ONE  = 4'd10,
        R_ZERO = 4'd11
    } reg_sel_t;

    typedef struct packed {
        op_t      op;
        reg_sel_t src_a;
        reg_sel_t src_b;
        reg_sel_t dst;
    } uop_t;

    localparam int NUM_UOPS  = 19;
    localparam int UOP_IDX_W = $clog2(NUM_UOPS);

    // s = x*x, d = s-1, xp1 = x+1
    // f = -(4*(a*(x*d))) - b
    // v = a*(d*d) + b*xp1
    // l = 4*(a*((s+s)+s-1))
    localparam uop_t UCODE [NUM_UOPS] = '{
        '{OP_MUL, R_X,    R_X,   R_S  },
        '{OP_SUB, R_S,    R_ONE, R_D  },
        '{OP_ADD, R_X,    R_ONE, R_XP1},
        '{OP_MUL, R_X,    R_D,   R_T  },
        '{OP_MUL, R_A,    R_T,   R_T  },
        '{OP_ADD, R_T,    R_T,   R_T  },
        '{OP_ADD, R_T,    R_T,   R_T  },
        '{OP_SUB, R_ZERO, R_T,   R_T  },
        '{OP_SUB, R_T,    R_B,   R_F  },
        '{OP_MUL, R_D,    R_D,   R_T  },
        '{OP_MUL, R_A,    R_T,   R_V  },
        '{OP_MUL, R_B,    R_XP1, R_T  },
        '{OP_ADD, R_V,    R_T,   R_V  },
        '{OP_ADD, R_S,    R_S,   R_T  },
        '{OP_ADD, R_T,    R_S,   R_T  },
        '{OP_SUB, R_T,    R_ONE, R_T  },
        '{OP_MUL, R_A,    R_T,   R_T  },
        '{OP_ADD, R_T,    R_T,   R_T  },
        '{OP_ADD, R_T,    R_T,   R_L  }
    };

endpackage

`default_nettype wire

// ===== rtl/core/dwfa_front.sv =====
// Front end: input handshake and coordinate classification.
// Moves the coordinate to 16 fractional bits, saturates it, and pushes it to the queue.
// Depends on dwfa_pkg.
`default_nettype none

module dwfa_front #(
    parameter int COORD_WIDTH = 16,
    parameter int ACC_WIDTH   = 40
) (
    input  logic                        coord_valid,
    output logic                        coord_ready,
    input  logic signed [COORD_WIDTH-1:0] coordinate,
    input  logic                        last_coordinate,
    input  logic                        full,
    output logic                        push,
    output logic signed [ACC_WIDTH-1:0] push_x,
    output logic                        push_last
);

    localparam int XW   = COORD_WIDTH + dwfa_pkg::COORD_SHIFT;
    localparam int CMPW = ((XW > ACC_WIDTH) ? XW : ACC_WIDTH) + 1;

    localparam logic signed [ACC_WIDTH-1:0] VMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] VMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic signed [XW-1:0]   x_wide;
    logic signed [CMPW-1:0] x_cmp;

    assign coord_ready = !full;
    assign push        = coord_valid && !full;
    assign push_last   = last_coordinate;

    assign x_wide = signed'({coordinate, {dwfa_pkg::COORD_SHIFT{1'b0}}});
    assign x_cmp  = CMPW'(x_wide);

    // clamp to the accumulator range
    always_comb
    begin
        priority if (x_cmp > CMPW'(VMAX))
        begin
            push_x = VMAX;
        end
        else if (x_cmp < CMPW'(VMIN))
        begin
            push_x = VMIN;
        end
        else
        begin
            push_x = x_cmp[ACC_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dwfa_queue.sv =====
// Short FIFO between the front end and the back end.
// Depth from dwfa_pkg::QUEUE_DEPTH; entries are registers, the head is picked by the read pointer.
// Depends on dwfa_pkg.
`default_nettype none

module dwfa_queue #(
    parameter int WIDTH = 41
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int DEPTH = dwfa_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dwfa_mul.sv =====
// Digit-serial fixed-point multiplier, one 16-bit digit of the second operand a cycle.
// Rounds half away from zero to 16 fractional bits and saturates to the accumulator range.
// Depends on dwfa_pkg.
`default_nettype none

module dwfa_mul #(
    parameter int ACC_WIDTH = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [ACC_WIDTH-1:0] op_a,
    input  logic signed [ACC_WIDTH-1:0] op_b,
    output logic                        done,
    output logic signed [ACC_WIDTH-1:0] product
);

    localparam int W     = ACC_WIDTH;
    localparam int DIG   = dwfa_pkg::MUL_DIGIT;
    localparam int FRAC  = dwfa_pkg::RES_FRAC;
    localparam int ND    = (W + DIG - 1) / DIG;
    localparam int LOW_W = ND * DIG;
    localparam int PW    = W + LOW_W;
    localparam int Q_W   = PW - FRAC + 1;
    localparam int CNT_W = (ND > 1) ? $clog2(ND) : 1;

    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    dwfa_pkg::mul_state_t state_reg, state_next;

    logic [W-1:0]        mag_a_reg, mag_a_next;
    logic [LOW_W-1:0]    mul_b_reg, mul_b_next;
    logic [W-1:0]        hi_reg, hi_next;
    logic [LOW_W-1:0]    lo_reg, lo_next;
    logic                neg_reg, neg_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic signed [W-1:0] product_reg, product_next;

    logic [W+DIG-1:0]    part;
    logic [W+DIG-1:0]    acc_sum;
    logic [PW-1:0]       full_prod;
    logic [Q_W-1:0]      rounded;
    logic [W-1:0]        mag_op_a;
    logic [W-1:0]        mag_op_b;

    assign done    = done_reg;
    assign product = product_reg;

    assign mag_op_a = op_a[W-1] ? W'(-op_a) : op_a;
    assign mag_op_b = op_b[W-1] ? W'(-op_b) : op_b;

    // one digit: partial product plus the running upper half
    assign part    = (W+DIG)'(mag_a_reg) * (W+DIG)'(mul_b_reg[DIG-1:0]);
    assign acc_sum = (W+DIG)'(hi_reg) + part;

    assign full_prod = {hi_reg, lo_reg};
    assign rounded   = Q_W'(full_prod[PW-1:FRAC]) + Q_W'(full_prod[FRAC-1]);

    always_comb
    begin
        state_next   = state_reg;
        mag_a_next   = mag_a_reg;
        mul_b_next   = mul_b_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        product_next = product_reg;

        unique case (state_reg)
            dwfa_pkg::M_IDLE:
            begin
                if (start)
                begin
                    mag_a_next = mag_op_a;
                    mul_b_next = LOW_W'(mag_op_b);
                    hi_next    = '0;
                    lo_next    = '0;
                    neg_next   = op_a[W-1] ^ op_b[W-1];
                    cnt_next   = CNT_W'(ND - 1);
                    state_next = dwfa_pkg::M_RUN;
                end
            end
            dwfa_pkg::M_RUN:
            begin
                hi_next    = acc_sum[W+DIG-1:DIG];
                lo_next    = {acc_sum[DIG-1:0], lo_reg[LOW_W-1:DIG]};
                mul_b_next = mul_b_reg >> DIG;
                if (cnt_reg == '0)
                begin
                    state_next = dwfa_pkg::M_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            dwfa_pkg::M_ROUND:
            begin
                // saturate the rounded magnitude, then apply the sign
                if (!neg_reg)
                begin
                    product_next = (rounded > Q_W'(VMAX)) ? VMAX : rounded[W-1:0];
                end
                else
                begin
                    product_next = (rounded > Q_W'(unsigned'(VMIN))) ? VMIN
                                                                      : -rounded[W-1:0];
                end
                done_next  = 1'b1;
                state_next = dwfa_pkg::M_IDLE;
            end
            default:
            begin
                state_next = dwfa_pkg::M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dwfa_pkg::M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg   <= mag_a_next;
        mul_b_reg   <= mul_b_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        neg_reg     <= neg_next;
        product_reg <= product_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/dwfa_back.sv =====
// Back end: micro-op sequencer, saturating ALU, running totals and output register.
// Runs the table dwfa_pkg::UCODE per item, using dwfa_mul for products.
// Depends on dwfa_pkg and dwfa_mul.
`default_nettype none

module dwfa_back #(
    parameter int ACC_WIDTH = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  logic signed [ACC_WIDTH-1:0] q_x,
    input  logic                        q_last,
    input  logic signed [ACC_WIDTH-1:0] well_a,
    input  logic signed [ACC_WIDTH-1:0] tilt_b,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic signed [ACC_WIDTH-1:0] force_res,
    output logic signed [ACC_WIDTH-1:0] potential_total,
    output logic signed [ACC_WIDTH-1:0] laplacian_total,
    output logic signed [ACC_WIDTH-1:0] field_total,
    output logic                        totals_valid
);

    localparam int W = ACC_WIDTH;
    localparam int IW = dwfa_pkg::UOP_IDX_W;

    localparam logic signed [W-1:0] VMAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE_Q =
        {{(W-dwfa_pkg::RES_FRAC-1){1'b0}}, 1'b1, {dwfa_pkg::RES_FRAC{1'b0}}};

    function automatic logic signed [W-1:0] sat_add(
        input logic signed [W-1:0] lhs,
        input logic signed [W-1:0] rhs,
        input logic                sub
    );
        logic signed [W:0] lx;
        logic signed [W:0] rx;
        logic signed [W:0] sum;
        lx  = (W+1)'(lhs);
        rx  = (W+1)'(rhs);
        sum = sub ? (lx - rx) : (lx + rx);
        if (sum[W] != sum[W-1])
        begin
            return sum[W] ? VMIN : VMAX;
        end
        return sum[W-1:0];
    endfunction

    dwfa_pkg::back_state_t state_reg, state_next;
    logic [IW-1:0]         uop_idx_reg, uop_idx_next;
    dwfa_pkg::uop_t        uop;

    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] s_reg, s_next;
    logic signed [W-1:0] d_reg, d_next;
    logic signed [W-1:0] xp1_reg, xp1_next;
    logic signed [W-1:0] t_reg, t_next;
    logic signed [W-1:0] v_reg, v_next;
    logic signed [W-1:0] f_reg, f_next;
    logic signed [W-1:0] l_reg, l_next;
    logic                last_reg, last_next;

    logic signed [W-1:0] pot_sum_reg, pot_sum_next;
    logic signed [W-1:0] lap_sum_reg, lap_sum_next;
    logic signed [W-1:0] fld_sum_reg, fld_sum_next;

    logic                res_valid_reg, res_valid_next;
    logic signed [W-1:0] force_reg, force_next;
    logic signed [W-1:0] pot_out_reg, pot_out_next;
    logic signed [W-1:0] lap_out_reg, lap_out_next;
    logic signed [W-1:0] fld_out_reg, fld_out_next;
    logic                tot_valid_reg, tot_valid_next;

    logic signed [W-1:0] src_a;
    logic signed [W-1:0] src_b;
    logic signed [W-1:0] alu_res;
    logic signed [W-1:0] wr_val;
    logic                wr_en;
    logic                mul_start;
    logic                mul_done;
    logic signed [W-1:0] mul_product;
    logic                out_free;
    logic signed [W-1:0] pot_acc;
    logic signed [W-1:0] lap_acc;
    logic signed [W-1:0] fld_acc;

    assign uop      = dwfa_pkg::UCODE[uop_idx_reg];
    assign out_free = !res_valid_reg || res_ready;

    assign res_valid       = res_valid_reg;
    assign force_res       = force_reg;
    assign potential_total = pot_out_reg;
    assign laplacian_total = lap_out_reg;
    assign field_total     = fld_out_reg;
    assign totals_valid    = tot_valid_reg;

    dwfa_mul #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (src_a),
        .op_b    (src_b),
        .done    (mul_done),
        .product (mul_product)
    );

    // operand select
    always_comb
    begin
        unique case (uop.src_a)
            dwfa_pkg::R_X:   src_a = x_reg;
            dwfa_pkg::R_A:   src_a = well_a;
            dwfa_pkg::R_B:   src_a = tilt_b;
            dwfa_pkg::R_S:   src_a = s_reg;
            dwfa_pkg::R_D:   src_a = d_reg;
            dwfa_pkg::R_XP1: src_a = xp1_reg;
            dwfa_pkg::R_T:   src_a = t_reg;
            dwfa_pkg::R_V:   src_a = v_reg;
            dwfa_pkg::R_F:   src_a = f_reg;
            dwfa_pkg::R_L:   src_a = l_reg;
            dwfa_pkg::R_ONE: src_a = ONE_Q;
            default:         src_a = '0;
        endcase
    end

    always_comb
    begin
        unique case (uop.src_b)
            dwfa_pkg::R_X:   src_b = x_reg;
            dwfa_pkg::R_A:   src_b = well_a;
            dwfa_pkg::R_B:   src_b = tilt_b;
            dwfa_pkg::R_S:   src_b = s_reg;
            dwfa_pkg::R_D:   src_b = d_reg;
            dwfa_pkg::R_XP1: src_b = xp1_reg;
            dwfa_pkg::R_T:   src_b = t_reg;
            dwfa_pkg::R_V:   src_b = v_reg;
            dwfa_pkg::R_F:   src_b = f_reg;
            dwfa_pkg::R_L:   src_b = l_reg;
            dwfa_pkg::R_ONE: src_b = ONE_Q;
            default:         src_b = '0;
        endcase
    end

    assign alu_res = sat_add(src_a, src_b, uop.op == dwfa_pkg::OP_SUB);

    assign pot_acc = sat_add(pot_sum_reg, v_reg, 1'b0);
    assign lap_acc = sat_add(lap_sum_reg, l_reg, 1'b0);
    assign fld_acc = sat_add(fld_sum_reg, xp1_reg, 1'b0);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        uop_idx_next = uop_idx_reg;
        q_pop        = 1'b0;
        mul_start    = 1'b0;
        wr_en        = 1'b0;
        wr_val       = alu_res;
        x_next       = x_reg;
        last_next    = last_reg;

        pot_sum_next   = pot_sum_reg;
        lap_sum_next   = lap_sum_reg;
        fld_sum_next   = fld_sum_reg;
        res_valid_next = res_valid_reg;
        force_next     = force_reg;
        pot_out_next   = pot_out_reg;
        lap_out_next   = lap_out_reg;
        fld_out_next   = fld_out_reg;
        tot_valid_next = tot_valid_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            dwfa_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    x_next       = q_x;
                    last_next    = q_last;
                    uop_idx_next = '0;
                    state_next   = dwfa_pkg::B_ISSUE;
                end
            end
            dwfa_pkg::B_ISSUE:
            begin
                if (uop.op == dwfa_pkg::OP_MUL)
                begin
                    mul_start  = 1'b1;
                    state_next = dwfa_pkg::B_WAIT;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (uop_idx_reg == IW'(dwfa_pkg::NUM_UOPS - 1))
                    begin
                        state_next = dwfa_pkg::B_OUT;
                    end
                    else
                    begin
                        uop_idx_next = uop_idx_reg + 1'b1;
                    end
                end
            end
            dwfa_pkg::B_WAIT:
            begin
                // hold the micro-op until the product lands
                if (mul_done)
                begin
                    wr_en  = 1'b1;
                    wr_val = mul_product;
                    if (uop_idx_reg == IW'(dwfa_pkg::NUM_UOPS - 1))
                    begin
                        state_next = dwfa_pkg::B_OUT;
                    end
                    else
                    begin
                        uop_idx_next = uop_idx_reg + 1'b1;
                        state_next   = dwfa_pkg::B_ISSUE;
                    end
                end
            end
            dwfa_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    force_next     = f_reg;
                    tot_valid_next = last_reg;
                    if (last_reg)
                    begin
                        pot_out_next = pot_acc;
                        lap_out_next = lap_acc;
                        fld_out_next = fld_acc;
                        pot_sum_next = '0;
                        lap_sum_next = '0;
                        fld_sum_next = '0;
                    end
                    else
                    begin
                        pot_out_next = '0;
                        lap_out_next = '0;
                        fld_out_next = '0;
                        pot_sum_next = pot_acc;
                        lap_sum_next = lap_acc;
                        fld_sum_next = fld_acc;
                    end
                    state_next = dwfa_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = dwfa_pkg::B_IDLE;
            end
        endcase
    end

    // write-back into the working registers
    always_comb
    begin
        s_next   = s_reg;
        d_next   = d_reg;
        xp1_next = xp1_reg;
        t_next   = t_reg;
        v_next   = v_reg;
        f_next   = f_reg;
        l_next   = l_reg;
        if (wr_en)
        begin
            unique case (uop.dst)
                dwfa_pkg::R_S:   s_next   = wr_val;
                dwfa_pkg::R_D:   d_next   = wr_val;
                dwfa_pkg::R_XP1: xp1_next = wr_val;
                dwfa_pkg::R_T:   t_next   = wr_val;
                dwfa_pkg::R_V:   v_next   = wr_val;
                dwfa_pkg::R_F:   f_next   = wr_val;
                dwfa_pkg::R_L:   l_next   = wr_val;
                default:         s_next   = s_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dwfa_pkg::B_IDLE;
            uop_idx_reg   <= '0;
            pot_sum_reg   <= '0;
            lap_sum_reg   <= '0;
            fld_sum_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            uop_idx_reg   <= uop_idx_next;
            pot_sum_reg   <= pot_sum_next;
            lap_sum_reg   <= lap_sum_next;
            fld_sum_reg   <= fld_sum_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        s_reg         <= s_next;
        d_reg         <= d_next;
        xp1_reg       <= xp1_next;
        t_reg         <= t_next;
        v_reg         <= v_next;
        f_reg         <= f_next;
        l_reg         <= l_next;
        last_reg      <= last_next;
        force_reg     <= force_next;
        pot_out_reg   <= pot_out_next;
        lap_out_reg   <= lap_out_next;
        fld_out_reg   <= fld_out_next;
        tot_valid_reg <= tot_valid_next;
    end

    a_start_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |=> state_reg == dwfa_pkg::B_WAIT)
        else $error("multiplier started but sequencer not waiting");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == dwfa_pkg::B_WAIT)
        else $error("product returned outside the wait state");

    a_totals_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !tot_valid_reg) |->
            (pot_out_reg == '0 && lap_out_reg == '0 && fld_out_reg == '0))
        else $error("totals nonzero on an item that is not last");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dwfa_pkg::B_OUT && out_free && last_reg) |=>
            (pot_sum_reg == '0 && lap_sum_reg == '0 && fld_sum_reg == '0))
        else $error("running totals not cleared after last item");

endmodule

`default_nettype wire

// ===== rtl/core/double_well_force_accumulator.sv =====
// Tilted double-well force accumulator. Each item carries one coordinate x (signed,
// 12 fractional bits) and a last-of-molecule flag; each item yields one result with the
// force -4a*x*(x^2-1) - b (16 fractional bits, saturated). The block keeps running totals
// of the potential a*(x^2-1)^2 + b*(x+1), the Laplacian 4a*(3x^2-1) and the field x+1;
// the result of the item flagged last carries those totals (that item included) with
// totals_valid high and clears them, while other results show zero totals. Coefficients
// a (well_depth, index 0, reset 1.0) and b (tilt, index 1, reset 0) are Q8.8 and are
// written through cfg_we/cfg_index/cfg_data; the user must write them only while no
// item is in flight, as the block does not enforce this. Items are worked one at a time,
// and the seven products of each item go through one shared multiplier that retires
// one 16-bit digit a cycle. A two-entry queue lets the input side take up to two items
// ahead, and the output register lets the next item run while a result waits.
// Depends on dwfa_pkg, dwfa_front, dwfa_queue, dwfa_back.
`default_nettype none

module double_well_force_accumulator #(
    parameter int COORD_WIDTH = 16,
    parameter int ACC_WIDTH   = 40
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          coord_valid,
    output logic                          coord_ready,
    input  logic signed [COORD_WIDTH-1:0] coordinate,
    input  logic                          last_coordinate,

    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [dwfa_pkg::COEF_WIDTH-1:0] cfg_data,

    output logic                          res_valid,
    input  logic                          res_ready,
    output logic signed [ACC_WIDTH-1:0]   force_res,
    output logic signed [ACC_WIDTH-1:0]   potential_total,
    output logic signed [ACC_WIDTH-1:0]   laplacian_total,
    output logic signed [ACC_WIDTH-1:0]   field_total,
    output logic                          totals_valid
);

    localparam int QW = ACC_WIDTH + 1;

    // Coefficient registers, Q8.8
    logic [dwfa_pkg::COEF_WIDTH-1:0] well_depth_reg, well_depth_next;
    logic [dwfa_pkg::COEF_WIDTH-1:0] tilt_reg, tilt_next;

    // Coefficients moved to 16 fractional bits
    logic signed [ACC_WIDTH-1:0] well_a;
    logic signed [ACC_WIDTH-1:0] tilt_b;

    // Front to queue
    logic                        push;
    logic signed [ACC_WIDTH-1:0] push_x;
    logic                        push_last;
    logic                        q_full;

    // Queue to back
    logic                        q_pop;
    logic                        q_valid;
    logic [QW-1:0]               q_data;

    always_comb
    begin
        well_depth_next = well_depth_reg;
        tilt_next       = tilt_reg;
        if (cfg_we)
        begin
            unique case (dwfa_pkg::cfg_idx_t'(cfg_index))
                dwfa_pkg::CFG_WELL_DEPTH: well_depth_next = cfg_data;
                dwfa_pkg::CFG_TILT:       tilt_next       = cfg_data;
                default:                  well_depth_next = well_depth_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            well_depth_reg <= dwfa_pkg::WELL_DEPTH_RESET;
            tilt_reg       <= dwfa_pkg::TILT_RESET;
        end
        else
        begin
            well_depth_reg <= well_depth_next;
            tilt_reg       <= tilt_next;
        end
    end

    // Shift left into the 16-fraction-bit format and sign-extend to full width
    assign well_a = ACC_WIDTH'(signed'({well_depth_reg, {dwfa_pkg::COEF_SHIFT{1'b0}}}));
    assign tilt_b = ACC_WIDTH'(signed'({tilt_reg, {dwfa_pkg::COEF_SHIFT{1'b0}}}));

    // Accept and classify the incoming item
    dwfa_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .ACC_WIDTH   (ACC_WIDTH)
    ) u_front (
        .coord_valid     (coord_valid),
        .coord_ready     (coord_ready),
        .coordinate      (coordinate),
        .last_coordinate (last_coordinate),
        .full            (q_full),
        .push            (push),
        .push_x          (push_x),
        .push_last       (push_last)
    );

    // Buffer classified items so the front and back stall independently
    dwfa_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_last, push_x}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    // Evaluate force and terms, accumulate and drive the result
    dwfa_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_x             (q_data[ACC_WIDTH-1:0]),
        .q_last          (q_data[ACC_WIDTH]),
        .well_a          (well_a),
        .tilt_b          (tilt_b),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .force_res       (force_res),
        .potential_total (potential_total),
        .laplacian_total (laplacian_total),
        .field_total     (field_total),
        .totals_valid    (totals_valid)
    );

endmodule

`default_nettype wire

// ===== test/double_well_force_accumulator_test.sv =====
// Self-checking testbench for double_well_force_accumulator: directed table plus random
// molecules under several coefficient settings, with a bit-exact fixed-point predictor.
// Depends on dwfa_pkg and the double_well_force_accumulator RTL.
`timescale 1ns / 100ps

module double_well_force_accumulator_test;
    import dwfa_pkg::*;

    localparam int     ACC_W       = 40;
    localparam longint SAT_MAX     = (longint'(1) << (ACC_W - 1)) - 1;
    localparam longint SAT_MIN     = -SAT_MAX - 1;
    localparam longint Q_ONE       = longint'(1) << RES_FRAC;
    localparam int     ITEM_CYCLES = 56;
    localparam int     PHASE_ITEMS = 175;
    localparam int     NUM_PHASES  = 6;
    localparam int     HOLD_AT     = 300;
    localparam int     HOLD_CYCLES = 600;
    // Slowest run is roughly 1100 items, each with its gap and stall, plus the hold-off
    localparam int     CYCLE_LIMIT = 400000;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_SPARSE,
        READY_MOSTLY
    } stall_mode_t;

    // One expected result: force on the coordinate and the molecule totals
    typedef struct {
        longint frc;
        longint pot;
        longint lap;
        longint fld;
        longint totals;
    } coord_result_t;

    // One directed row; typed rows carry the expected result written out by hand
    typedef struct {
        logic [15:0] x;
        logic        last;
        bit          typed;
        longint      frc;
        longint      pot;
        longint      lap;
        longint      fld;
    } coord_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    coord_valid;
    logic                    coord_ready;
    logic signed [15:0]      coordinate;
    logic                    last_coordinate;
    logic                    cfg_we;
    logic [0:0]              cfg_index;
    logic [COEF_WIDTH-1:0]   cfg_data;
    logic                    res_valid;
    logic                    res_ready;
    logic signed [ACC_W-1:0] force_res;
    logic signed [ACC_W-1:0] potential_total;
    logic signed [ACC_W-1:0] laplacian_total;
    logic signed [ACC_W-1:0] field_total;
    logic                    totals_valid;

    // Predictor copy of the coefficients and the running totals
    logic signed [15:0] depth_coef;
    logic signed [15:0] tilt_coef;
    longint             pot_acc;
    longint             lap_acc;
    longint             fld_acc;

    coord_result_t coord_results [$];
    coord_result_t got_result;
    int            errors;
    int            results_seen;
    int            cycle_count;
    int            burst_left;
    int            hold_left;
    bit            hold_done;
    int            mode_left;
    stall_mode_t   stall_mode;

    // Hand-checked rows at reset coefficients (a = 1.0, b = 0); the rest go to the predictor
    coord_row_t dir_rows [13] = '{
        '{16'h0000, 1'b1, 1'b1, 0, 65536, -262144, 65536},
        '{16'h1000, 1'b1, 1'b1, 0, 0, 524288, 131072},
        '{16'hF000, 1'b1, 1'b1, 0, 0, 524288, 0},
        '{16'h8000, 1'b1, 1'b1, 132120576, 260112384, 50069504, -458752},
        '{16'h7FFF, 1'b0, 1'b0, 0, 0, 0, 0},
        '{16'h0800, 1'b0, 1'b1, 98304, 0, 0, 0},
        '{16'h0001, 1'b0, 1'b0, 0, 0, 0, 0},
        '{16'hFFFF, 1'b0, 1'b0, 0, 0, 0, 0},
        '{16'h5555, 1'b0, 1'b0, 0, 0, 0, 0},
        '{16'hAAAA, 1'b1, 1'b0, 0, 0, 0, 0},
        '{16'h7FFF, 1'b1, 1'b0, 0, 0, 0, 0},
        '{16'h8000, 1'b0, 1'b0, 0, 0, 0, 0},
        '{16'h8000, 1'b1, 1'b0, 0, 0, 0, 0}
    };

    double_well_force_accumulator i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .coord_valid     (coord_valid),
        .coord_ready     (coord_ready),
        .coordinate      (coordinate),
        .last_coordinate (last_coordinate),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .force_res       (force_res),
        .potential_total (potential_total),
        .laplacian_total (laplacian_total),
        .field_total     (field_total),
        .totals_valid    (totals_valid)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Fixed-point predictor: 16 fractional bits, saturated to ACC_W bits
    // ---------------------------------------------------------------
    function automatic longint sat(longint v);
        if (v > SAT_MAX)
            return SAT_MAX;
        if (v < SAT_MIN)
            return SAT_MIN;
        return v;
    endfunction

    // Exact product, rounded half away from zero, then saturated
    function automatic longint fx_mul(longint p, longint q);
        logic [127:0] mp;
        logic [127:0] mq;
        logic [127:0] prod;
        logic         neg;
        neg  = (p < 0) != (q < 0);
        mp   = (p < 0) ? 128'(-p) : 128'(p);
        mq   = (q < 0) ? 128'(-q) : 128'(q);
        prod = (mp * mq + (128'(1) << (RES_FRAC - 1))) >> RES_FRAC;
        if (!neg)
            return (prod > 128'(SAT_MAX)) ? SAT_MAX : longint'(prod);
        return (prod > 128'(SAT_MAX) + 1) ? SAT_MIN : -longint'(prod);
    endfunction

    // Two saturating doublings, as the block does them
    function automatic longint times4(longint v);
        return sat(2 * sat(2 * v));
    endfunction

    // Work out the result of one accepted coordinate and queue it
    task automatic compute_well_terms(input logic [15:0] raw, input logic last);
        longint        x;
        longint        a;
        longint        b;
        longint        s;
        longint        d;
        longint        xp1;
        coord_result_t r;
        x   = longint'($signed(raw)) * (longint'(1) << COORD_SHIFT);
        a   = longint'(depth_coef) * (longint'(1) << COEF_SHIFT);
        b   = longint'(tilt_coef) * (longint'(1) << COEF_SHIFT);
        s   = fx_mul(x, x);
        d   = sat(s - Q_ONE);
        xp1 = sat(x + Q_ONE);

        r.frc   = sat(sat(0 - times4(fx_mul(a, fx_mul(x, d)))) - b);
        pot_acc = sat(pot_acc + sat(fx_mul(a, fx_mul(d, d)) + fx_mul(b, xp1)));
        lap_acc = sat(lap_acc + times4(fx_mul(a, sat(sat(sat(s + s) + s) - Q_ONE))));
        fld_acc = sat(fld_acc + xp1);

        // Totals show only on the last coordinate of a molecule, then clear
        if (last) begin
            r.pot    = pot_acc;
            r.lap    = lap_acc;
            r.fld    = fld_acc;
            r.totals = 1;
            pot_acc  = 0;
            lap_acc  = 0;
            fld_acc  = 0;
        end
        else begin
            r.pot    = 0;
            r.lap    = 0;
            r.fld    = 0;
            r.totals = 0;
        end
        coord_results.push_back(r);
    endtask

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------

    // Offer one item, hold it until accepted, then predict it
    task automatic send_coord(input logic [15:0] x, input logic last);
        coord_valid     <= 1'b1;
        coordinate      <= x;
        last_coordinate <= last;
        do
            @(posedge clk);
        while (!coord_ready);
        compute_well_terms(x, last);
    endtask

    // Count down the burst; at its end drop valid for a random gap, which may be empty
    task automatic idle_gap();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                coord_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 16);
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_drained();
        coord_valid <= 1'b0;
        while (coord_results.size() != 0)
            @(posedge clk);
    endtask

    // Write both coefficients back to back; only while the block is idle
    task automatic set_coeffs(input logic [15:0] a_val, input logic [15:0] b_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WELL_DEPTH;
        cfg_data  <= a_val;
        @(posedge clk);
        depth_coef = a_val;
        cfg_index <= CFG_TILT;
        cfg_data  <= b_val;
        @(posedge clk);
        tilt_coef = b_val;
        cfg_we    <= 1'b0;
    endtask

    // One molecule; extreme ones sit near +-8 so the totals can saturate
    task automatic send_molecule(input int len, input bit extreme);
        logic [15:0] x;
        logic [15:0] corners [7];
        corners = '{16'h7FFF, 16'h8000, 16'h1000, 16'hF000, 16'h0000, 16'h0001, 16'hFFFF};
        for (int i = 0; i < len; i++) begin
            if (extreme)
                x = $urandom_range(0, 1) ? 16'h8000 + 16'($urandom_range(0, 255))
                                         : 16'h7FFF - 16'($urandom_range(0, 255));
            else if ($urandom_range(0, 7) == 0)
                x = corners[$urandom_range(0, 6)];
            else
                x = 16'($urandom);
            send_coord(x, i == len - 1);
            idle_gap();
        end
    endtask

    // ---------------------------------------------------------------
    // Main stimulus
    // ---------------------------------------------------------------
    initial begin
        int          sent;
        int          len;
        logic [15:0] phase_a [NUM_PHASES];
        logic [15:0] phase_b [NUM_PHASES];

        clk             = 1'b0;
        rst_n           = 1'b0;
        coord_valid     = 1'b0;
        coordinate      = '0;
        last_coordinate = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_WELL_DEPTH;
        cfg_data        = '0;
        res_ready       = 1'b0;
        depth_coef      = WELL_DEPTH_RESET;
        tilt_coef       = TILT_RESET;
        pot_acc         = 0;
        lap_acc         = 0;
        fld_acc         = 0;
        burst_left      = 0;

        // Coefficient settings per phase; extremes of both signs, one random pair
        phase_a = '{16'h0100, 16'h7FFF, 16'h8000, 16'h0000, 16'($urandom), 16'h7FFF};
        phase_b = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'($urandom), 16'h8000};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset coefficients; typed rows replace the prediction
        foreach (dir_rows[i]) begin
            send_coord(dir_rows[i].x, dir_rows[i].last);
            if (dir_rows[i].typed)
                coord_results[$] = '{dir_rows[i].frc, dir_rows[i].pot, dir_rows[i].lap,
                                     dir_rows[i].fld, longint'(dir_rows[i].last)};
            idle_gap();
        end

        // Random phases: one long extreme molecule first, then mostly short ones
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            @(posedge clk);
            set_coeffs(phase_a[p], phase_b[p]);
            len = $urandom_range(40, 120);
            send_molecule(len, 1'b1);
            sent = len;
            while (sent < PHASE_ITEMS) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
                send_molecule(len, $urandom_range(0, 9) == 0);
                sent += len;
            end
        end

        wait_drained();
        repeat (2 * ITEM_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver side: stall patterns plus one long hold-off that backs up the input
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            res_ready <= 1'b0;
        end
        else begin
            if (mode_left == 0) begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                READY_ALWAYS: res_ready <= 1'b1;
                READY_RANDOM: res_ready <= 1'($urandom_range(0, 1));
                READY_SPARSE: res_ready <= (mode_left % 4 == 0);
                default:      res_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Checking: compare each accepted result with the oldest expectation
    // ---------------------------------------------------------------
    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            results_seen++;
            if (coord_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual force %0d",
                         $time, force_res);
            end
            else begin
                got_result = coord_results.pop_front();
                check_field("force_res", got_result.frc, longint'(force_res));
                check_field("potential_total", got_result.pot, longint'(potential_total));
                check_field("laplacian_total", got_result.lap, longint'(laplacian_total));
                check_field("field_total", got_result.fld, longint'(field_total));
                check_field("totals_valid", got_result.totals, longint'(totals_valid));
            end
        end
    end

    // Give up on a hang
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

// ===== files.f =====
rtl/core/dwfa_pkg.sv
rtl/core/dwfa_front.sv
rtl/core/dwfa_queue.sv
rtl/core/dwfa_mul.sv
rtl/core/dwfa_back.sv
rtl/core/double_well_force_accumulator.sv
test/double_well_force_accumulator_test.sv
